/* design/isort_pkg.sv */
// Shared types and constants for the insertion sorter.
// Used by isort_cell and insertion_sorter; no dependencies.
package isort_pkg;

  localparam int MAX_ELEMENTS = 16;
  localparam int VAL_W        = 16;

  typedef enum logic [0:0] {
    ST_FILL,
    ST_DRAIN
  } state_t;

  // broadcast to every cell
  typedef struct packed {
    logic                    ins;    // insert key this cycle
    logic                    shift;  // move contents one cell toward cell 0
    logic signed [VAL_W-1:0] key;
  } cell_ctl_t;

  // what a cell shows its neighbors
  typedef struct packed {
    logic                    valid;
    logic                    gt;     // holds a value greater than key, or empty
    logic signed [VAL_W-1:0] value;
  } cell_nb_t;

endpackage

/* design/isort_cell.sv */
// One compare-and-shift cell of the sort chain.
// Depends on isort_pkg for the control and neighbor structs.
module isort_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  isort_pkg::cell_ctl_t ctl,
  input  isort_pkg::cell_nb_t  left,
  input  isort_pkg::cell_nb_t  right,
  output isort_pkg::cell_nb_t  self
);
  import isort_pkg::*;

  logic                    valid_r, valid_nxt;
  logic signed [VAL_W-1:0] value_r, value_nxt;

  always_comb begin
    self.valid = valid_r;
    self.value = value_r;
    self.gt    = !valid_r || (value_r > ctl.key);
  end

  always_comb begin
    value_nxt = value_r;
    valid_nxt = valid_r;
    if (ctl.shift) begin
      value_nxt = right.value;
      valid_nxt = right.valid;
    end else if (ctl.ins) begin
      // greater values move up one place; the key lands after equal ones
      if (self.gt) begin
        value_nxt = (left.valid && left.gt) ? left.value : ctl.key;
      end
      valid_nxt = valid_r | left.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    value_r <= value_nxt;
  end

endmodule

/* design/insertion_sorter.sv */
// Insertion sorter: takes one item per cycle into a chain of MAX_ELEMENTS cells
// that keep the set in ascending order; the first result is offered in the
// cycle after the last item is taken. The set drains one item per cycle from
// cell 0 while out_tready is high; input is held off during the drain.
// Reset (synchronous, active low) empties the chain and clears the overflow flag.
module insertion_sorter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] value
  input  logic        in_tlast,   // is_last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] sorted_value
  output logic        out_tlast,  // end_of_set
  output logic        out_tuser   // [0] overflow
);
  import isort_pkg::*;

  state_t    state_r, state_nxt;
  logic      dropped_r, dropped_nxt;
  cell_ctl_t ctl;
  cell_nb_t  nb [MAX_ELEMENTS];
  cell_nb_t  edge_left, edge_right;
  logic      in_acc, out_acc, full, final_out;

  assign in_acc    = in_tvalid && in_tready;
  assign out_acc   = out_tvalid && out_tready;
  assign full      = nb[MAX_ELEMENTS-1].valid;
  assign final_out = !nb[1].valid;

  // cell 0 sees a valid, never-greater neighbor on its left
  always_comb begin
    edge_left.valid  = 1'b1;
    edge_left.gt     = 1'b0;
    edge_left.value  = '0;
    edge_right.valid = 1'b0;
    edge_right.gt    = 1'b1;
    edge_right.value = '0;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_FILL:  if (in_acc && in_tlast) state_nxt = ST_DRAIN;
      ST_DRAIN: if (out_acc && final_out) state_nxt = ST_FILL;
      default:  state_nxt = ST_FILL;
    endcase
  end

  always_comb begin
    in_tready   = (state_r == ST_FILL);
    out_tvalid  = (state_r == ST_DRAIN);
    ctl.key     = $signed(in_tdata);
    ctl.ins     = in_acc && !full;
    ctl.shift   = out_acc;
    dropped_nxt = dropped_r;
    if (in_acc && full) begin
      dropped_nxt = 1'b1;
    end
    if (out_acc && final_out) begin
      dropped_nxt = 1'b0;
    end
  end

  assign out_tdata = nb[0].value;
  assign out_tlast = final_out;
  assign out_tuser = dropped_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_FILL;
      dropped_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      dropped_r <= dropped_nxt;
    end
  end

  for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
    cell_nb_t l_nb, r_nb;
    if (i == 0) begin : g_first
      assign l_nb = edge_left;
    end else begin : g_mid_l
      assign l_nb = nb[i-1];
    end
    if (i == MAX_ELEMENTS-1) begin : g_last
      assign r_nb = edge_right;
    end else begin : g_mid_r
      assign r_nb = nb[i+1];
    end
    isort_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (ctl),
      .left  (l_nb),
      .right (r_nb),
      .self  (nb[i])
    );
  end

endmodule
